/* rtl/dtpa_pkg.sv */
// Shared types and constants for the dual tachometer period averager.
// Used by dtpa_front, dtpa_div, dtpa_back and the top level; depends on nothing.
package dtpa_pkg;

    // Item mode codes.
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_REARM = 2'd3;

    // Fixed field widths.
    localparam int STAMP_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int ACC_W    = 32;
    localparam int MEAN_W   = 24;

    // Saturation limits.
    localparam logic [ACC_W-1:0]  ACC_MAX  = 32'hFFFF_FFFF;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 24'hFF_FFFF;

    // The mean divider produces one quotient bit per cycle.
    localparam int DIV_STEPS = MEAN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic               is_edge;
        logic               is_start;
        logic               is_stop;
        logic               is_rearm;
        logic               channel;
        logic [STAMP_W-1:0] timestamp;
    } t_cmd;

    // One finished result item.
    typedef struct packed {
        logic                channel;
        logic [PERIOD_W-1:0] period;
        logic [ACC_W-1:0]    tick_sum;
        logic [ACC_W-1:0]    edge_count;
        logic [MEAN_W-1:0]   mean_period;
        logic                measuring;
    } t_result;

endpackage

/* rtl/dtpa_front.sv */
// Front part: accepts input items, decodes the mode and queues the commands.
// Depends on dtpa_pkg.
module dtpa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic                        i_channel,
    input  logic [dtpa_pkg::STAMP_W-1:0] i_timestamp,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output dtpa_pkg::t_cmd              o_cmd
);

    dtpa_pkg::t_cmd                         w_cmd;
    dtpa_pkg::t_cmd                         r_q [dtpa_pkg::QUEUE_DEPTH];
    logic [dtpa_pkg::QUEUE_PTR_W-1:0]       r_wr;
    logic [dtpa_pkg::QUEUE_PTR_W-1:0]       r_rd;
    logic [dtpa_pkg::QUEUE_CNT_W-1:0]       r_cnt;
    logic                                   w_push;
    logic                                   w_pop;

    // Decode the mode into one command flag.
    always_comb begin
        w_cmd           = '0;
        w_cmd.channel   = i_channel;
        w_cmd.timestamp = i_timestamp;
        unique case (i_mode)
            dtpa_pkg::MODE_EDGE:  w_cmd.is_edge  = 1'b1;
            dtpa_pkg::MODE_START: w_cmd.is_start = 1'b1;
            dtpa_pkg::MODE_STOP:  w_cmd.is_stop  = 1'b1;
            dtpa_pkg::MODE_REARM: w_cmd.is_rearm = 1'b1;
            default:              w_cmd.is_rearm = 1'b1;
        endcase
    end

    assign o_in_ready  = (r_cnt != dtpa_pkg::QUEUE_CNT_W'(dtpa_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Queue storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == dtpa_pkg::QUEUE_PTR_W'(dtpa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == dtpa_pkg::QUEUE_PTR_W'(dtpa_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/dtpa_div.sv */
// Radix-2 restoring divider for the Q16.8 mean, one quotient bit per cycle.
// Expects the high half of the numerator below the divisor. Depends on dtpa_pkg.
module dtpa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dtpa_pkg::ACC_W-1:0]    i_num,
    input  logic [dtpa_pkg::ACC_W-1:0]    i_den,
    output logic                          o_done,
    output logic [dtpa_pkg::MEAN_W-1:0]   o_quot
);

    logic [dtpa_pkg::ACC_W-1:0]     r_rem;
    logic [dtpa_pkg::MEAN_W-1:0]    r_dvd;
    logic [dtpa_pkg::ACC_W-1:0]     r_den;
    logic [dtpa_pkg::MEAN_W-1:0]    r_quo;
    logic [dtpa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [dtpa_pkg::ACC_W:0]       w_trial;
    logic                           w_fits;

    // Shift the next numerator bit into the partial remainder and compare.
    assign w_trial = {r_rem, r_dvd[dtpa_pkg::MEAN_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {16'd0, i_num[dtpa_pkg::ACC_W-1:16]};
            r_dvd <= {i_num[15:0], 8'd0};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? dtpa_pkg::ACC_W'(w_trial - {1'b0, r_den})
                            : w_trial[dtpa_pkg::ACC_W-1:0];
            r_dvd <= {r_dvd[dtpa_pkg::MEAN_W-2:0], 1'b0};
            r_quo <= {r_quo[dtpa_pkg::MEAN_W-2:0], w_fits};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dtpa_pkg::DIV_CNT_W'(dtpa_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* rtl/dtpa_back.sv */
// Back part: applies each command to the channel state, forms the mean and
// holds the result in the output register. Depends on dtpa_pkg and dtpa_div.
module dtpa_back #(
    parameter int TIMER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  dtpa_pkg::t_cmd    i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtpa_pkg::t_result o_res
);

    // Stored stamps never exceed the timestamp field or the timer width.
    localparam int SW = (TIMER_BITS < dtpa_pkg::STAMP_W) ? TIMER_BITS : dtpa_pkg::STAMP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    dtpa_pkg::t_cmd                 r_cmd;
    dtpa_pkg::t_result              r_res;
    dtpa_pkg::t_result              r_out;
    logic                           r_out_valid;
    logic [SW-1:0]                  r_stamp [2];
    logic [dtpa_pkg::ACC_W-1:0]     r_sum [2];
    logic [dtpa_pkg::ACC_W-1:0]     r_count [2];
    logic                           r_measure;

    logic [SW-1:0]                  w_ts;
    logic [TIMER_BITS-1:0]          w_diff;
    logic [TIMER_BITS-1:0]          w_period;
    logic [dtpa_pkg::ACC_W:0]       w_sum_wide;
    logic [dtpa_pkg::ACC_W-1:0]     w_sum;
    logic [dtpa_pkg::ACC_W-1:0]     w_count;
    logic                           w_measure;
    logic                           w_mean_zero;
    logic                           w_mean_sat;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [dtpa_pkg::MEAN_W-1:0]    w_quot;
    logic                           w_load;

    // Period since the channel's last edge, modulo the timer width.
    assign w_ts       = r_cmd.timestamp[SW-1:0];
    assign w_diff     = TIMER_BITS'(w_ts) - TIMER_BITS'(r_stamp[r_cmd.channel]);
    assign w_period   = r_cmd.is_edge ? w_diff : '0;
    assign w_sum_wide = {1'b0, r_sum[r_cmd.channel]} + (dtpa_pkg::ACC_W + 1)'(w_diff);

    // Updated sum, count and measuring flag for the addressed channel.
    always_comb begin
        w_sum     = r_sum[r_cmd.channel];
        w_count   = r_count[r_cmd.channel];
        w_measure = r_measure;
        if (r_cmd.is_edge && r_measure) begin
            w_sum = w_sum_wide[dtpa_pkg::ACC_W] ? dtpa_pkg::ACC_MAX
                                                : w_sum_wide[dtpa_pkg::ACC_W-1:0];
            if (w_count != dtpa_pkg::ACC_MAX) begin
                w_count = w_count + 1'b1;
            end
        end else if (r_cmd.is_start) begin
            w_sum     = '0;
            w_count   = '0;
            w_measure = 1'b1;
        end else if (r_cmd.is_stop) begin
            w_measure = 1'b0;
        end
    end

    // The mean is zero when idle or empty, and saturates once sum/count reaches 2^16.
    assign w_mean_zero = !w_measure || (w_sum == '0) || (w_count == '0);
    assign w_mean_sat  = (dtpa_pkg::ACC_W'(w_sum[dtpa_pkg::ACC_W-1:16]) >= w_count);
    assign w_div_start = (r_state == ST_EXEC) && !w_mean_zero && !w_mean_sat;
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_cmd_ready = (r_state == ST_IDLE);

    dtpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_sum),
        .i_den   (w_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_cmd_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = w_div_start ? ST_DIV : ST_DONE;
            ST_DIV:  if (w_div_done) n_state = ST_DONE;
            ST_DONE: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_EXEC) begin
            r_res.channel    <= r_cmd.channel;
            r_res.period     <= dtpa_pkg::PERIOD_W'(w_period);
            r_res.tick_sum   <= w_sum;
            r_res.edge_count <= w_count;
            r_res.measuring  <= w_measure;
            r_res.mean_period <= w_mean_zero ? '0 : dtpa_pkg::MEAN_MAX;
        end else if ((r_state == ST_DIV) && w_div_done) begin
            r_res.mean_period <= w_quot;
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    // Channel state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp[0] <= '0;
            r_stamp[1] <= '0;
            r_sum[0]   <= '0;
            r_sum[1]   <= '0;
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_measure  <= 1'b0;
        end else if (r_state == ST_EXEC) begin
            r_measure <= w_measure;
            if (r_cmd.is_edge) begin
                r_stamp[r_cmd.channel] <= w_ts;
                r_sum[r_cmd.channel]   <= w_sum;
                r_count[r_cmd.channel] <= w_count;
            end else if (r_cmd.is_start) begin
                r_sum[0]   <= '0;
                r_sum[1]   <= '0;
                r_count[0] <= '0;
                r_count[1] <= '0;
            end else if (r_cmd.is_rearm) begin
                r_stamp[0] <= w_ts;
                r_stamp[1] <= w_ts;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* rtl/dual_tachometer_period_averager.sv */
// Dual tachometer period averager: edge timer with per-channel mean period.
// Input items (mode, channel, timestamp) enter on a valid/ready channel and each
// transfer produces exactly one result transfer on the output valid/ready channel.
// An edge reports the ticks since that channel's previous edge, modulo
// 2^TIMER_BITS; while measuring, the period is added to a saturating sum and the
// edge count rises. Start clears both channels and begins measuring, stop ends
// it, rearm loads both last stamps from the timestamp.
// A command that needs a mean division passes through the shared restoring
// divider, which yields one of 24 quotient bits per cycle; other commands skip
// it. The execution unit takes the next command only once the current result
// has been loaded into the output register.
// A two-entry queue sits between the input decoder and the execution unit, so
// inputs keep being accepted while a result waits in the output register.
// When the receiver stalls, the result holds in the output register, the
// execution unit waits with the next finished result, and input ready drops
// once the queue is full.
// Reset (synchronous, active low) clears stamps, sums, counts, the measuring
// flag, the queue and the output valid.
// Depends on dtpa_pkg, dtpa_front, dtpa_div and dtpa_back.
module dual_tachometer_period_averager #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic        i_channel,
    input  logic [15:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_channel,
    output logic [15:0] o_period,
    output logic [31:0] o_tick_sum,
    output logic [31:0] o_edge_count,
    output logic [23:0] o_mean_period,
    output logic        o_measuring
);

    logic              w_cmd_valid;
    logic              w_cmd_ready;
    dtpa_pkg::t_cmd    w_cmd;
    dtpa_pkg::t_result w_res;

    dtpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_channel   (i_channel),
        .i_timestamp (i_timestamp),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    dtpa_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    // Unpack the result onto the output ports.
    assign o_out_channel = w_res.channel;
    assign o_period      = w_res.period;
    assign o_tick_sum    = w_res.tick_sum;
    assign o_edge_count  = w_res.edge_count;
    assign o_mean_period = w_res.mean_period;
    assign o_measuring   = w_res.measuring;

endmodule
